@@ sv/lsbse_pkg.sv @@
// Shared types, register indexes and result codes for the LSB stego extractor.
`timescale 1ns / 1ps

package lsbse_pkg;

  localparam int unsigned EXT_CHARS = 4;

  localparam logic [7:0] HEADER_SKIP_RST  = 8'd54;
  localparam logic [7:0] MAGIC_FIRST_RST  = 8'd35;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'd42;

  localparam int unsigned CFG_AW = 4;

  localparam logic [1:0] REG_HEADER_SKIP  = 2'd0;
  localparam logic [1:0] REG_MAGIC_FIRST  = 2'd1;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd2;

  localparam logic [2:0] KIND_MISMATCH  = 3'd0;
  localparam logic [2:0] KIND_EXT_SIZE  = 3'd1;
  localparam logic [2:0] KIND_EXT_CHAR  = 3'd2;
  localparam logic [2:0] KIND_PAY_SIZE  = 3'd3;
  localparam logic [2:0] KIND_PAY_BYTE  = 3'd4;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [31:0] decoded_value;
    logic [2:0]  result_kind;
    logic        message_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] header_skip;
    logic [7:0] magic_first;
    logic [7:0] magic_second;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

@@ sv/lsbse_cfg_regs.sv @@
// APB-style configuration registers: header skip and the magic pair.
`timescale 1ns / 1ps

module lsbse_cfg_regs
  import lsbse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_skip  <= HEADER_SKIP_RST;
      cfg_r.magic_first  <= MAGIC_FIRST_RST;
      cfg_r.magic_second <= MAGIC_SECOND_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEADER_SKIP:  cfg_r.header_skip  <= pwdata[7:0];
        REG_MAGIC_FIRST:  cfg_r.magic_first  <= pwdata[7:0];
        REG_MAGIC_SECOND: cfg_r.magic_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEADER_SKIP:  prdata = {24'd0, cfg_r.header_skip};
      REG_MAGIC_FIRST:  prdata = {24'd0, cfg_r.magic_first};
      REG_MAGIC_SECOND: prdata = {24'd0, cfg_r.magic_second};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ sv/lsbse_in_stage.sv @@
// Input register: holds one accepted item until the parser takes it.
`timescale 1ns / 1ps

module lsbse_in_stage
  import lsbse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     held_valid,
  output in_item_t held_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

@@ sv/lsbse_parser.sv @@
// Frame parser: header skip, LSB gathering and the per-phase decode of one item.
`timescale 1ns / 1ps

module lsbse_parser
  import lsbse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  in_item_t item,
  input  cfg_t     cfg,
  output res_t     res
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_MAGIC   = 3'd1;
  localparam logic [2:0] PH_EXTSIZE = 3'd2;
  localparam logic [2:0] PH_EXTCHR  = 3'd3;
  localparam logic [2:0] PH_PAYSIZE = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_IDLE    = 3'd6;

  localparam logic [2:0] EXT_LAST = 3'(EXT_CHARS);

  logic [2:0]  phase_r,        phase_nxt;
  logic [7:0]  header_count_r, header_count_nxt;
  logic [4:0]  bit_count_r,    bit_count_nxt;
  logic [31:0] bit_gather_r,   bit_gather_nxt;
  logic [2:0]  char_count_r,   char_count_nxt;
  logic [7:0]  first_magic_r,  first_magic_nxt;
  logic [31:0] payload_left_r, payload_left_nxt;

  logic [31:0] gathered;
  logic [5:0]  bc_inc;
  logic        wide;
  logic        complete;
  logic [2:0]  cc_inc;
  logic [31:0] pl_dec;

  always_comb begin
    // frame_start restarts the parser on this very byte
    if (item.frame_start) begin
      phase_nxt        = PH_HEADER;
      header_count_nxt = 8'd0;
      bit_count_nxt    = 5'd0;
      bit_gather_nxt   = 32'd0;
      char_count_nxt   = 3'd0;
      first_magic_nxt  = 8'd0;
      payload_left_nxt = 32'd0;
    end else begin
      phase_nxt        = phase_r;
      header_count_nxt = header_count_r;
      bit_count_nxt    = bit_count_r;
      bit_gather_nxt   = bit_gather_r;
      char_count_nxt   = char_count_r;
      first_magic_nxt  = first_magic_r;
      payload_left_nxt = payload_left_r;
    end
    res = '0;

    if (phase_nxt == PH_HEADER) begin
      if (header_count_nxt < cfg.header_skip) begin
        header_count_nxt = header_count_nxt + 8'd1;
      end else begin
        phase_nxt = PH_MAGIC;
      end
    end

    gathered = {bit_gather_nxt[30:0], item.image_byte[0]};
    bc_inc   = {1'b0, bit_count_nxt} + 6'd1;
    wide     = (phase_nxt == PH_EXTSIZE) || (phase_nxt == PH_PAYSIZE);
    complete = wide ? (bc_inc >= 6'd32) : (bc_inc >= 6'd8);
    cc_inc   = char_count_nxt + 3'd1;
    pl_dec   = payload_left_nxt - 32'd1;

    unique case (phase_nxt)
      PH_MAGIC: begin
        bit_gather_nxt = gathered;
        bit_count_nxt  = complete ? 5'd0 : bc_inc[4:0];
        if (complete) begin
          if (char_count_nxt == 3'd0) begin
            first_magic_nxt = gathered[7:0];
            char_count_nxt  = 3'd1;
          end else begin
            char_count_nxt = 3'd0;
            if (first_magic_nxt == cfg.magic_first && gathered[7:0] == cfg.magic_second) begin
              phase_nxt = PH_EXTSIZE;
            end else begin
              phase_nxt                  = PH_IDLE;
              res.valid                  = 1'b1;
              res.item.decoded_value     = {16'd0, first_magic_nxt, gathered[7:0]};
              res.item.result_kind       = KIND_MISMATCH;
              res.item.message_end       = 1'b1;
            end
          end
        end
      end
      PH_EXTSIZE: begin
        bit_gather_nxt = gathered;
        bit_count_nxt  = complete ? 5'd0 : bc_inc[4:0];
        if (complete) begin
          phase_nxt              = PH_EXTCHR;
          char_count_nxt         = 3'd0;
          res.valid              = 1'b1;
          res.item.decoded_value = gathered;
          res.item.result_kind   = KIND_EXT_SIZE;
        end
      end
      PH_EXTCHR: begin
        bit_gather_nxt = gathered;
        bit_count_nxt  = complete ? 5'd0 : bc_inc[4:0];
        if (complete) begin
          if (cc_inc >= EXT_LAST) begin
            char_count_nxt = 3'd0;
            phase_nxt      = PH_PAYSIZE;
          end else begin
            char_count_nxt = cc_inc;
          end
          res.valid              = 1'b1;
          res.item.decoded_value = {24'd0, gathered[7:0]};
          res.item.result_kind   = KIND_EXT_CHAR;
        end
      end
      PH_PAYSIZE: begin
        bit_gather_nxt = gathered;
        bit_count_nxt  = complete ? 5'd0 : bc_inc[4:0];
        if (complete) begin
          payload_left_nxt       = gathered;
          res.valid              = 1'b1;
          res.item.decoded_value = gathered;
          res.item.result_kind   = KIND_PAY_SIZE;
          if (gathered == 32'd0) begin
            phase_nxt            = PH_IDLE;
            res.item.message_end = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        bit_gather_nxt = gathered;
        bit_count_nxt  = complete ? 5'd0 : bc_inc[4:0];
        if (complete) begin
          payload_left_nxt       = pl_dec;
          res.valid              = 1'b1;
          res.item.decoded_value = {24'd0, gathered[7:0]};
          res.item.result_kind   = KIND_PAY_BYTE;
          if (pl_dec == 32'd0) begin
            phase_nxt            = PH_IDLE;
            res.item.message_end = 1'b1;
          end
        end
      end
      // header still counting, idle, or the unused code: drop the byte
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_count_r <= 8'd0;
      bit_count_r    <= 5'd0;
      bit_gather_r   <= 32'd0;
      char_count_r   <= 3'd0;
      first_magic_r  <= 8'd0;
      payload_left_r <= 32'd0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      bit_gather_r   <= bit_gather_nxt;
      char_count_r   <= char_count_nxt;
      first_magic_r  <= first_magic_nxt;
      payload_left_r <= payload_left_nxt;
    end
  end

endmodule

@@ sv/lsbse_out_stage.sv @@
// Result register: holds one decoded item until the consumer takes it.
`timescale 1ns / 1ps

module lsbse_out_stage
  import lsbse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  res_t      res,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;
  logic      load;

  assign load     = advance && res.valid;
  assign out_free = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res.item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ sv/lsb_stego_message_extractor.sv @@
// Top level of the LSB stego message extractor.
// Streams an image file one byte per item, skips header_skip bytes, then
// rebuilds hidden characters and 32-bit sizes from the byte LSBs (MSB first),
// checks the two magic characters (a mismatch result if they differ) and emits
// extension size, extension characters, payload size and payload bytes;
// message_end marks the last result of a frame. One item is accepted per cycle;
// the held item is decoded and any result is loaded into the result register as
// that item advances. The single-pass parse step between the input and result
// registers sets that rate; the pipe only stalls while out_ready low holds a result.
`timescale 1ns / 1ps

module lsb_stego_message_extractor
  import lsbse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg;
  logic     held_valid;
  in_item_t held_item;
  logic     out_free;
  logic     advance;
  res_t     res;

  assign advance = held_valid && out_free;

  lsbse_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsbse_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  lsbse_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .res     (res)
  );

  lsbse_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ sv/lsbse_checker.sv @@
// Port-level checks on the extractor's result channel and config port.
`timescale 1ns / 1ps

module lsbse_checker
  import lsbse_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_item,
  input logic [31:0] prdata,
  input logic        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_mismatch_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind == KIND_MISMATCH |->
      out_item.message_end && out_item.decoded_value[31:16] == 16'd0)
    else $error("mismatch item malformed");

  a_ext_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.result_kind == KIND_EXT_SIZE ||
                  out_item.result_kind == KIND_EXT_CHAR) |-> !out_item.message_end)
    else $error("extension item flagged as message end");

  a_char_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.result_kind == KIND_EXT_CHAR ||
                  out_item.result_kind == KIND_PAY_BYTE) |->
      out_item.decoded_value[31:8] == 24'd0)
    else $error("character item has upper bits set");

  a_cfg_port: assert property (@(posedge clk) disable iff (!rst_n)
    pready && prdata[31:8] == 24'd0)
    else $error("config port read data or ready wrong");

endmodule

bind lsb_stego_message_extractor lsbse_checker u_lsbse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .prdata    (prdata),
  .pready    (pready)
);

@@ sim/lsb_stego_message_extractor_tb.sv @@
// Self-checking testbench for the LSB stego message extractor: hidden-bit frames, checked results.
`timescale 1ns / 1ps

module lsb_stego_message_extractor_tb;
  import lsbse_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int NO_CUT = 1 << 30;

  typedef enum logic [2:0] {
    ST_HEADER, ST_MAGIC, ST_EXT_SIZE, ST_EXT_CHAR, ST_PAY_SIZE, ST_PAYLOAD, ST_DONE
  } parse_st_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lsb_stego_message_extractor uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Register copy and parser state of the decoder model
  cfg_t regs = '{header_skip: HEADER_SKIP_RST, magic_first: MAGIC_FIRST_RST,
                 magic_second: MAGIC_SECOND_RST};
  parse_st_t st = ST_HEADER;
  logic [7:0] hdr_cnt = '0;
  int bit_cnt = 0;
  logic [31:0] gather = '0;
  logic [2:0] chr_cnt = '0;
  logic [7:0] first_ch = '0;
  logic [31:0] pay_left = '0;

  in_item_t image_q[$];
  out_item_t decoded_q[$];
  out_item_t next_res;

  int send_idle = 0;
  int recv_idle = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  bit start_next = 1'b0;
  int bit_budget = NO_CUT;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int frames_built = 0;
  int results_seen = 0;
  int frame_ends = 0;
  int reg_writes = 0;
  int errors = 0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic out_item_t make_res(input logic [31:0] v, input logic [2:0] k,
                                         input logic e);
    out_item_t r;
    r.decoded_value = v;
    r.result_kind = k;
    r.message_end = e;
    return r;
  endfunction

  function automatic void restart_parse();
    st = ST_HEADER;
    hdr_cnt = '0;
    bit_cnt = 0;
    gather = '0;
    chr_cnt = '0;
    first_ch = '0;
    pay_left = '0;
  endfunction

  // Shift one hidden bit in; true once 'need' bits are gathered
  function automatic bit shift_in(input logic b, input int need);
    gather = {gather[30:0], b};
    if (bit_cnt + 1 >= need) begin
      bit_cnt = 0;
      return 1'b1;
    end
    bit_cnt = bit_cnt + 1;
    return 1'b0;
  endfunction

  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    logic b;
    logic [7:0] ch;
    res = '0;
    b = it.image_byte[0];
    if (it.frame_start) restart_parse();
    if (st == ST_HEADER) begin
      if (hdr_cnt < regs.header_skip) begin
        hdr_cnt = hdr_cnt + 8'd1;
        return 1'b0;
      end
      st = ST_MAGIC;
    end
    case (st)
      ST_MAGIC: begin
        if (!shift_in(b, 8)) return 1'b0;
        ch = gather[7:0];
        if (chr_cnt == 3'd0) begin
          first_ch = ch;
          chr_cnt = 3'd1;
          return 1'b0;
        end
        chr_cnt = 3'd0;
        if (first_ch == regs.magic_first && ch == regs.magic_second) begin
          st = ST_EXT_SIZE;
          return 1'b0;
        end
        st = ST_DONE;
        res = make_res({16'd0, first_ch, ch}, KIND_MISMATCH, 1'b1);
        return 1'b1;
      end
      ST_EXT_SIZE: begin
        if (!shift_in(b, 32)) return 1'b0;
        st = ST_EXT_CHAR;
        chr_cnt = 3'd0;
        res = make_res(gather, KIND_EXT_SIZE, 1'b0);
        return 1'b1;
      end
      ST_EXT_CHAR: begin
        if (!shift_in(b, 8)) return 1'b0;
        chr_cnt = chr_cnt + 3'd1;
        if (chr_cnt >= 3'(EXT_CHARS)) begin
          chr_cnt = 3'd0;
          st = ST_PAY_SIZE;
        end
        res = make_res({24'd0, gather[7:0]}, KIND_EXT_CHAR, 1'b0);
        return 1'b1;
      end
      ST_PAY_SIZE: begin
        if (!shift_in(b, 32)) return 1'b0;
        pay_left = gather;
        if (pay_left == 32'd0) begin
          st = ST_DONE;
          res = make_res(32'd0, KIND_PAY_SIZE, 1'b1);
        end else begin
          st = ST_PAYLOAD;
          res = make_res(pay_left, KIND_PAY_SIZE, 1'b0);
        end
        return 1'b1;
      end
      ST_PAYLOAD: begin
        if (!shift_in(b, 8)) return 1'b0;
        pay_left = pay_left - 32'd1;
        if (pay_left == 32'd0) st = ST_DONE;
        res = make_res({24'd0, gather[7:0]}, KIND_PAY_BYTE, pay_left == 32'd0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Image byte driver: predict on acceptance, then offer the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_taken++;
        if (decode_byte(in_item, next_res)) decoded_q.push_back(next_res);
      end
      if (!in_valid || in_ready) begin
        if (image_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_item <= image_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result value=%h kind=%0d end=%0b",
                              got.decoded_value, got.result_kind, got.message_end));
      return;
    end
    want = decoded_q.pop_front();
    results_seen++;
    if (got.message_end) frame_ends++;
    if (got.decoded_value !== want.decoded_value)
      flag_mismatch($sformatf("decoded_value %h, want %h", got.decoded_value,
                              want.decoded_value));
    if (got.result_kind !== want.result_kind)
      flag_mismatch($sformatf("result_kind %0d, want %0d", got.result_kind,
                              want.result_kind));
    if (got.message_end !== want.message_end)
      flag_mismatch($sformatf("message_end %0b, want %0b", got.message_end,
                              want.message_end));
  endtask

  // Result monitor; a hold request stalls the receiver for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_item);
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results outstanding", quiet_cycles,
                 decoded_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HEADER_SKIP: regs.header_skip = val;
      REG_MAGIC_FIRST: regs.magic_first = val;
      REG_MAGIC_SECOND: regs.magic_second = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Hold off until the queue is drained and every result is back, then let the pipe empty
  task automatic wait_idle();
    do @(negedge clk); while (image_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idle(input int snd, input int rcv);
    @(posedge clk);
    send_idle <= snd;
    recv_idle <= rcv;
  endtask

  task automatic push_byte(input logic [7:0] b);
    in_item_t it;
    it.image_byte = b;
    it.frame_start = start_next;
    start_next = 1'b0;
    image_q.push_back(it);
    bytes_queued++;
  endtask

  // Hide the low n bits of v, MSB first, in the LSBs of random bytes
  task automatic push_bits(input logic [31:0] v, input int n);
    logic [6:0] r;
    for (int i = n - 1; i >= 0; i--) begin
      if (bit_budget > 0) begin
        bit_budget--;
        r = 7'($urandom);
        push_byte({r, v[i]});
      end
    end
  endtask

  task automatic push_body(input logic [31:0] ext_size, input logic [31:0] ext_word,
                           input logic [31:0] pay_size, input int pay_sent);
    push_bits(ext_size, 32);
    for (int i = 0; i < EXT_CHARS; i++) begin
      push_bits({24'd0, ext_word[31:24]}, 8);
      ext_word = {ext_word[23:0], ext_word[31:24]};
    end
    push_bits(pay_size, 32);
    for (int i = 0; i < pay_sent; i++) push_bits(32'($urandom), 8);
  endtask

  task automatic push_frame(input bit fs, input logic [7:0] skip, input logic [7:0] m1,
                            input logic [7:0] m2, input logic [31:0] ext_size,
                            input logic [31:0] ext_word, input logic [31:0] pay_size,
                            input int pay_sent);
    start_next = fs;
    frames_built++;
    for (int i = 0; i < skip; i++) push_byte(8'($urandom));
    push_bits({24'd0, m1}, 8);
    push_bits({24'd0, m2}, 8);
    push_body(ext_size, ext_word, pay_size, pay_sent);
  endtask

  task automatic push_random_frame();
    int pick;
    int len;
    pick = $urandom_range(99);
    len = $urandom_range(6);
    bit_budget = NO_CUT;
    if (pick < 60) begin
      push_frame(1'b1, regs.header_skip, regs.magic_first, regs.magic_second,
                 32'($urandom), 32'($urandom), len, len);
      // trailing bytes after the frame end are dropped by the block
      repeat ($urandom_range(2)) push_byte(8'($urandom));
    end else if (pick < 68) begin
      // huge unsigned size, cut short by the next frame start
      push_frame(1'b1, regs.header_skip, regs.magic_first, regs.magic_second,
                 32'($urandom), 32'($urandom), 32'($urandom) | 32'h8000_0000,
                 $urandom_range(1, 4));
    end else if (pick < 80) begin
      push_frame(1'b1, regs.header_skip, 8'($urandom), 8'($urandom),
                 32'($urandom), 32'($urandom), len, len);
    end else if (pick < 92) begin
      bit_budget = $urandom_range(110);
      push_frame(1'b1, regs.header_skip, regs.magic_first, regs.magic_second,
                 32'($urandom), 32'($urandom), 6, 6);
      bit_budget = NO_CUT;
    end else begin
      repeat ($urandom_range(1, 10)) begin
        start_next = ($urandom_range(3) == 0);
        push_byte(8'($urandom));
      end
    end
  endtask

  task automatic random_frames();
    int mark;
    mark = bytes_queued + RANDOM_PER_PHASE;
    while (bytes_queued < mark) push_random_frame();
  endtask

  task automatic random_config();
    wait_idle();
    write_reg(REG_HEADER_SKIP, 8'($urandom_range(12)));
    write_reg(REG_MAGIC_FIRST, 8'($urandom));
    write_reg(REG_MAGIC_SECOND, 8'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(26, 81);

    // Stream from reset with no frame start; the empty payload ends the frame on the size
    push_frame(1'b0, HEADER_SKIP_RST, MAGIC_FIRST_RST, MAGIC_SECOND_RST, 32'hFFFF_FFFF,
               32'h00FF_7F80, 32'd0, 0);
    // trailing bytes after the frame end are dropped
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h01);
    wait_idle();

    write_reg(REG_HEADER_SKIP, 8'd0);
    write_reg(REG_MAGIC_FIRST, 8'h00);
    write_reg(REG_MAGIC_SECOND, 8'hFF);
    bit_budget = 16;
    push_frame(1'b1, 8'd0, 8'h00, 8'hFE, 0, 0, 0, 0);
    bit_budget = 16;
    push_frame(1'b1, 8'd0, 8'hFF, 8'hFF, 0, 0, 0, 0);
    bit_budget = NO_CUT;
    wait_idle();

    // Shrink header_skip below the bytes already skipped
    write_reg(REG_HEADER_SKIP, 8'd255);
    start_next = 1'b1;
    repeat (10) push_byte(8'($urandom));
    wait_idle();
    write_reg(REG_HEADER_SKIP, 8'd3);
    bit_budget = 48;
    push_frame(1'b0, 8'd0, 8'h00, 8'hFF, 32'h8000_0001, 32'h4142_4344, 32'd2, 2);
    bit_budget = NO_CUT;
    wait_idle();

    // Change the magic registers while the second magic char is half gathered
    start_next = 1'b1;
    repeat (3) push_byte(8'($urandom));
    bit_budget = 12;
    push_bits(32'h0000_00A5, 8);
    push_bits(32'h0000_005A, 8);
    bit_budget = NO_CUT;
    wait_idle();
    write_reg(REG_MAGIC_FIRST, 8'hA5);
    write_reg(REG_MAGIC_SECOND, 8'h5A);
    bit_budget = 36;
    push_bits(32'h0000_005A, 4);
    push_body(32'h1234_5678, 32'($urandom), 32'd3, 3);
    bit_budget = NO_CUT;
    frames_built++;

    random_frames();
    random_config();

    wait_idle();
    set_idle(81, 26);
    random_frames();
    random_config();

    wait_idle();
    set_idle(0, 0);
    random_config();
    // Long receiver stall while the sender keeps pushing a frame with a payload
    push_frame(1'b1, regs.header_skip, regs.magic_first, regs.magic_second,
               32'($urandom), 32'($urandom), 32'd6, 6);
    @(posedge clk);
    hold_req <= ~hold_req;

    wait_idle();
    repeat (10) @(posedge clk);
    $display("ran %0d image bytes in %0d frames over %0d register writes", bytes_taken,
             frames_built, reg_writes);
    $display("checked %0d results, %0d of them frame ends, %0d mismatches", results_seen,
             frame_ends, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lsbse_pkg.sv
sv/lsbse_cfg_regs.sv
sv/lsbse_in_stage.sv
sv/lsbse_parser.sv
sv/lsbse_out_stage.sv
sv/lsb_stego_message_extractor.sv
sv/lsbse_checker.sv
sim/lsb_stego_message_extractor_tb.sv
